@@ hdl/pdji_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet drop and jitter impairer package
// Shared types, constants and the xorshift step used by the impairer.
// ----------------------------------------------------------------------------
package pdji_pkg;

   localparam int unsigned TAG_W     = 16;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned DELAY_W   = 16;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0]  GOLDEN_SEED  = 32'h9E37_79B9;
   localparam logic [DELAY_W-1:0] DROP_MODULUS = 16'd100;
   localparam logic [DELAY_W-1:0] JITTER_LIMIT = 16'd60000;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_PERCENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JITTER_MAX   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_VALUE   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DROP,
      ST_JITTER,
      ST_HOLD
   } state_type;

   // Request to the shared remainder unit.
   typedef struct packed {
      logic               start;
      logic [WORD_W-1:0]  dividend;
      logic [DELAY_W-1:0] divisor;
   } div_req_type;

   // Status back from the shared remainder unit.
   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DELAY_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [WORD_W-1:0] xorshift_step(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      a = x ^ (x << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage

@@ hdl/pdji_remainder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Impairer remainder unit
// Restoring remainder of a 32-bit dividend by a 16-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module pdji_remainder_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  pdji_pkg::div_req_type div_req,
   output pdji_pkg::div_rsp_type div_rsp
);
   import pdji_pkg::*;

   localparam int unsigned CNT_W = $clog2(WORD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [WORD_W-1:0]  dividend_ff, dividend_in;
   logic [DELAY_W-1:0] divisor_ff, divisor_in;
   logic [DELAY_W-1:0] rem_ff, rem_in;
   logic [DELAY_W:0]   trial;
   logic [DELAY_W:0]   diff;

   // The partial remainder stays below the divisor, so one extra bit holds
   // the shifted trial value.
   assign trial = {rem_ff, dividend_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (div_req.start) begin
         busy_in     = 1'b1;
         cnt_in      = '0;
         dividend_in = div_req.dividend;
         divisor_in  = div_req.divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[WORD_W-2:0], 1'b0};
         rem_in      = diff[DELAY_W] ? trial[DELAY_W-1:0] : diff[DELAY_W-1:0];
         cnt_in      = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("remainder unit reports done while still busy");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_req.start && cnt_ff == CNT_W'(WORD_W - 1)) |=> done_ff)
      else $error("remainder unit missed its done after the last step");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor_ff))
      else $error("remainder is not below the divisor");

endmodule

@@ hdl/packet_drop_jitter_impairer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet drop and jitter impairer
// Decides for each offered packet whether to drop it and how long to delay it.
// ----------------------------------------------------------------------------
// Each item on the req_ channel is one offered packet. The block draws from a
// 32-bit xorshift generator and returns one item on the rsp_ channel with the
// echoed tag, a drop flag and a delay in milliseconds. With dropping enabled,
// a draw modulo 100 below the drop percent drops the packet; a passed packet
// with jitter enabled takes a further draw, and the delay is that draw modulo
// the jitter maximum plus one, with the maximum capped at 60000. All
// remainders come from one shared bit-serial remainder unit, and the input
// is stalled from the accept until the result moves to the output register.
// A finished item sits in an output register, so the next packet can be
// taken while the previous result waits on rsp_stall. Configuration writes
// are always ready and belong in idle periods; writing the seed register
// reloads the generator with the seed XOR 0x9E3779B9, with zero made one.
// ----------------------------------------------------------------------------
module packet_drop_jitter_impairer_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Offered packets.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pdji_pkg::TAG_W-1:0]          req_packet_tag,
   // Decisions.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pdji_pkg::TAG_W-1:0]          rsp_result_tag,
   output logic                                rsp_drop_packet,
   output logic [pdji_pkg::DELAY_W-1:0]        rsp_jitter_delay,
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pdji_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdji_pkg::WORD_W-1:0]         csr_data
);
   import pdji_pkg::*;

   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  gen_ff, gen_in;
   logic [PCT_W-1:0]   drop_pct_ff, drop_pct_in;
   logic [DELAY_W-1:0] jitter_ff, jitter_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic               res_drop_ff, res_drop_in;
   logic [DELAY_W-1:0] res_delay_ff, res_delay_in;
   logic               out_valid_ff, out_valid_in;
   logic [TAG_W-1:0]   out_tag_ff, out_tag_in;
   logic               out_drop_ff, out_drop_in;
   logic [DELAY_W-1:0] out_delay_ff, out_delay_in;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               accept;
   logic               csr_write;
   logic               out_free;
   logic               out_load;
   logic               gen_step;
   logic               res_load;
   logic               drop_on;
   logic               jitter_on;
   logic               drop_hit;
   logic [WORD_W-1:0]  draw;
   logic [WORD_W-1:0]  seeded;
   logic [DELAY_W-1:0] jitter_sat;
   logic [DELAY_W-1:0] jitter_div;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = (state_ff != ST_IDLE);

   assign drop_on    = (drop_pct_ff != '0);
   assign jitter_on  = (jitter_ff != '0);
   assign draw       = xorshift_step(gen_ff);
   assign seeded     = csr_data ^ GOLDEN_SEED;
   assign jitter_sat = (jitter_ff > JITTER_LIMIT) ? JITTER_LIMIT : jitter_ff;
   assign jitter_div = jitter_sat + 1'b1;
   // The remainder by 100 is below 100, so a percent above 100 always drops.
   assign drop_hit   = (div_rsp.remainder < {{(DELAY_W - PCT_W){1'b0}}, drop_pct_ff});
   assign out_free   = !out_valid_ff || !rsp_stall;

   pdji_remainder_unit u_remainder (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (drop_on) state_in = ST_DROP;
               else if (jitter_on)   state_in = ST_JITTER;
               else                  state_in = ST_HOLD;
            end
         end
         ST_DROP: begin
            if (div_rsp.done) begin
               priority if (drop_hit) state_in = ST_HOLD;
               else if (jitter_on)    state_in = ST_JITTER;
               else                   state_in = ST_HOLD;
            end
         end
         ST_JITTER: begin
            if (div_rsp.done) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: draws, remainder requests and result loads.
   always_comb begin
      div_req      = '0;
      gen_step     = 1'b0;
      res_load     = 1'b0;
      res_drop_in  = 1'b0;
      res_delay_in = '0;
      out_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (drop_on) begin
                  gen_step         = 1'b1;
                  div_req.start    = 1'b1;
                  div_req.dividend = draw;
                  div_req.divisor  = DROP_MODULUS;
               end else if (jitter_on) begin
                  gen_step         = 1'b1;
                  div_req.start    = 1'b1;
                  div_req.dividend = draw;
                  div_req.divisor  = jitter_div;
               end else begin
                  res_load = 1'b1;
               end
            end
         end
         ST_DROP: begin
            if (div_rsp.done) begin
               priority if (drop_hit) begin
                  res_load    = 1'b1;
                  res_drop_in = 1'b1;
               end else if (jitter_on) begin
                  gen_step         = 1'b1;
                  div_req.start    = 1'b1;
                  div_req.dividend = draw;
                  div_req.divisor  = jitter_div;
               end else begin
                  res_load = 1'b1;
               end
            end
         end
         ST_JITTER: begin
            if (div_rsp.done) begin
               res_load     = 1'b1;
               res_delay_in = div_rsp.remainder;
            end
         end
         ST_HOLD: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // Register and generator updates.
   always_comb begin
      drop_pct_in = drop_pct_ff;
      jitter_in   = jitter_ff;
      gen_in      = gen_ff;
      if (gen_step) gen_in = draw;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DROP_PERCENT: drop_pct_in = csr_data[PCT_W-1:0];
            CSR_JITTER_MAX:   jitter_in   = csr_data[DELAY_W-1:0];
            CSR_SEED_VALUE:   gen_in      = (seeded == '0) ? WORD_W'(1) : seeded;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      tag_in       = accept ? req_packet_tag : tag_ff;
      out_valid_in = out_load ? 1'b1 : (out_valid_ff && rsp_stall);
      out_tag_in   = out_load ? tag_ff : out_tag_ff;
      out_drop_in  = out_load ? res_drop_ff : out_drop_ff;
      out_delay_in = out_load ? res_delay_ff : out_delay_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= GOLDEN_SEED;
         drop_pct_ff  <= '0;
         jitter_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         drop_pct_ff  <= drop_pct_in;
         jitter_ff    <= jitter_in;
         out_valid_ff <= out_valid_in;
      end
      tag_ff       <= tag_in;
      if (res_load) begin
         res_drop_ff  <= res_drop_in;
         res_delay_ff <= res_delay_in;
      end
      out_tag_ff   <= out_tag_in;
      out_drop_ff  <= out_drop_in;
      out_delay_ff <= out_delay_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_tag   = out_tag_ff;
   assign rsp_drop_packet  = out_drop_ff;
   assign rsp_jitter_delay = out_delay_ff;

   a_start_from_known_state: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (state_ff == ST_IDLE || state_ff == ST_DROP))
      else $error("remainder unit started outside a draw state");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input not stalled while an item is in work");

   a_dropped_has_no_delay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drop_packet) |-> (rsp_jitter_delay == '0))
      else $error("dropped item reports a nonzero delay");

   a_delay_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_jitter_delay <= JITTER_LIMIT))
      else $error("delay exceeds the jitter limit");

endmodule
